@@ rtl/core/kwm_pkg.sv @@
`timescale 1ns / 1ps

package kwm_pkg;

	localparam int NUM_LISTS   = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int VALUE_WIDTH = 32;

	localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = LIST_W + PTR_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;

	typedef enum logic [1:0] {
		ST_APPENDED = 2'd0,
		ST_FULL     = 2'd1,
		ST_PULLED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic                   vld;
		logic [LIST_W-1:0]      idx;
		logic [VALUE_WIDTH-1:0] val;
	} head_node_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

endpackage

@@ rtl/core/kwm_ram.sv @@
`timescale 1ns / 1ps

module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/kwm_head_sel.sv @@
`timescale 1ns / 1ps

module kwm_head_sel (
	input  logic [kwm_pkg::VALUE_WIDTH-1:0] head_val [kwm_pkg::NUM_LISTS],
	input  logic                            nonempty [kwm_pkg::NUM_LISTS],
	output kwm_pkg::head_node_t             best
);

	localparam int LEAVES = 1 << kwm_pkg::LIST_W;

	kwm_pkg::head_node_t node [1:2*LEAVES-1];

	always_comb begin
		kwm_pkg::head_node_t l;
		kwm_pkg::head_node_t r;
		l = '0;
		r = '0;
		for (int j = 0; j < LEAVES; j++) begin
			if (j < kwm_pkg::NUM_LISTS) begin
				node[LEAVES + j].vld = nonempty[j];
				node[LEAVES + j].idx = kwm_pkg::LIST_W'(j);
				node[LEAVES + j].val = head_val[j];
			end else begin
				node[LEAVES + j] = '0;
			end
		end
		// lower index wins ties
		for (int i = LEAVES - 1; i >= 1; i--) begin
			l = node[2*i];
			r = node[2*i + 1];
			if (l.vld && (!r.vld || ($signed(l.val) <= $signed(r.val)))) begin
				node[i] = l;
			end else begin
				node[i] = r;
			end
		end
	end

	assign best = node[1];

endmodule

@@ rtl/core/k_way_sorted_merge.sv @@
`timescale 1ns / 1ps
// a request's result is held in the output register from the cycle after the request is taken
// appends and final pulls do not stall the next request; a pull that leaves its queue non-empty
// stalls requests while the next head is read back from the store ram, as does a held result
// reset: arst_n clears all pointers, counts and handshake state at once; the store needs no clearing
module k_way_sorted_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               kind,
	input  logic [2:0]         list_index,
	input  logic signed [31:0] value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         status,
	output logic signed [31:0] out_value,
	output logic [2:0]         source_list
);

	localparam int LW = kwm_pkg::LIST_W;
	localparam int PW = kwm_pkg::PTR_W;
	localparam int CW = kwm_pkg::CNT_W;
	localparam int VW = kwm_pkg::VALUE_WIDTH;
	localparam int NL = kwm_pkg::NUM_LISTS;

	logic [PW-1:0] head_ptr_q [NL];
	logic [PW-1:0] tail_ptr_q [NL];
	logic [CW-1:0] cnt_q      [NL];
	logic [VW-1:0] head_val_q [NL];
	logic          nonempty   [NL];

	logic          busy_q;
	logic [LW-1:0] refill_list_q;
	logic          result_valid_q;
	logic [1:0]    status_q;
	logic [31:0]   out_value_q;
	logic [2:0]    source_q;

	kwm_pkg::head_node_t best;

	logic              accept;
	logic [LW-1:0]     sel_list;
	logic              in_range;
	logic [CW-1:0]     sel_cnt;
	logic              full;
	logic              do_app;
	logic              do_pull;
	logic              refill;
	logic [PW-1:0]     next_head;
	logic [PW-1:0]     next_tail;
	logic [VW-1:0]     wdata;
	logic [VW-1:0]     rdata;
	logic [LW+PW-1:0]  waddr;
	logic [LW+PW-1:0]  raddr;

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			nonempty[i] = (cnt_q[i] != '0);
		end
	end

	kwm_head_sel u_head_sel (
		.head_val (head_val_q),
		.nonempty (nonempty),
		.best     (best)
	);

	always_comb begin
		accept    = item_valid & ~item_stall;
		sel_list  = kind ? best.idx : LW'(list_index);
		in_range  = (int'(list_index) < NL);
		sel_cnt   = cnt_q[sel_list];
		full      = (sel_cnt >= CW'(kwm_pkg::QUEUE_DEPTH));
		do_app    = accept & ~kind & in_range & ~full;
		do_pull   = accept & kind & best.vld;
		refill    = do_pull & (sel_cnt > CW'(1));
		next_head = kwm_pkg::ptr_inc(head_ptr_q[sel_list]);
		next_tail = kwm_pkg::ptr_inc(tail_ptr_q[sel_list]);
		wdata     = VW'(value);
		waddr     = {sel_list, tail_ptr_q[sel_list]};
		raddr     = {sel_list, next_head};
	end

	kwm_ram #(
		.WIDTH (VW),
		.DEPTH (kwm_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_app),
		.waddr (waddr),
		.wdata (wdata),
		.re    (refill),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NL; i++) begin
				head_ptr_q[i] <= '0;
				tail_ptr_q[i] <= '0;
				cnt_q[i]      <= '0;
			end
			busy_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			for (int i = 0; i < NL; i++) begin
				if (do_app && (sel_list == LW'(i))) begin
					tail_ptr_q[i] <= next_tail;
					cnt_q[i]      <= cnt_q[i] + CW'(1);
				end
				if (do_pull && (sel_list == LW'(i))) begin
					head_ptr_q[i] <= next_head;
					cnt_q[i]      <= cnt_q[i] - CW'(1);
				end
			end
			busy_q <= refill;
			if (accept) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NL; i++) begin
			if (do_app && (sel_list == LW'(i)) && (cnt_q[i] == '0)) begin
				head_val_q[i] <= wdata;
			end
			if (busy_q && (refill_list_q == LW'(i))) begin
				head_val_q[i] <= rdata;
			end
		end
		if (refill) begin
			refill_list_q <= sel_list;
		end
		if (accept) begin
			if (kind) begin
				if (best.vld) begin
					status_q    <= kwm_pkg::ST_PULLED;
					out_value_q <= 32'($signed(best.val));
					source_q    <= 3'(best.idx);
				end else begin
					status_q    <= kwm_pkg::ST_EMPTY;
					out_value_q <= '0;
					source_q    <= '0;
				end
			end else begin
				status_q    <= do_app ? kwm_pkg::ST_APPENDED : kwm_pkg::ST_FULL;
				out_value_q <= '0;
				source_q    <= '0;
			end
		end
	end

	assign item_stall   = busy_q | (result_valid_q & result_stall);
	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign out_value    = out_value_q;
	assign source_list  = source_q;

endmodule

@@ rtl/core/kwm_checker.sv @@
`timescale 1ns / 1ps

module kwm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic               kind,
	input logic [2:0]         list_index,
	input logic signed [31:0] value,
	input logic               result_valid,
	input logic               result_stall,
	input logic [1:0]         status,
	input logic signed [31:0] out_value,
	input logic [2:0]         source_list
);

	// a held result blocks new requests
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> item_stall)
		else $error("request taken while result held");

	// every taken request yields a result next cycle
	a_req_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> result_valid)
		else $error("request without result");

	// payload is zero unless a value was pulled
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != kwm_pkg::ST_PULLED) |-> (out_value == 0) && (source_list == 0))
		else $error("nonzero payload on non-pull result");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status))
		else $error("stalled result changed");

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (.*);
